>>> rtl/core/bss_pkg.sv
// Package for the blend sample selector: widths and constants.
`timescale 1ns / 1ps
package bss_pkg;
	localparam int MAX_ENTRIES_DEF = 256;
	localparam int MAX_DIMS_DEF    = 3;
	localparam int COORD_BITS_DEF  = 24;
	localparam int DATA_BITS       = 24;
	localparam int CFG_IDX_BITS    = 2;
	localparam int CFG_DATA_BITS   = 9;
	localparam int ALPHA_BITS      = 17;
	localparam int IDX_BITS        = 8;
	localparam int CNT_BITS        = 9;

	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_DIMS    = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_SAMPLES = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COORDS  = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_WRAP  = 2'd3;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam longint HALF_TURN = 46080;
	localparam longint FULL_TURN = 92160;
	localparam longint ALPHA_ONE = 65536;
endpackage

>>> rtl/core/blend_sample_selector.sv
// Top level of the blend sample selector: table, sequencer and shared datapath.
`timescale 1ns / 1ps
// A load or an unchanged query goes from idle to ST_OUT, which raises out_valid.
// A 1-D query reads and compares each sample walked (ST_RD1, ST_CMP1) and runs the divide when it brackets.
// An N-D query reads, differences and squares each coordinate (ST_RDN, ST_DIFF, ST_SQ) and
// closes each sample in ST_NEXT; with angle wrap on, ST_WRAP removes one 360-degree turn per step.
// One item at a time: in_stall stays high until the result has been taken. Reset
// (arst_n low) clears state, configuration, held selection and active query; the
// coordinate table is not cleared and must be written before it is read.
module blend_sample_selector #(
	parameter int MAX_ENTRIES = bss_pkg::MAX_ENTRIES_DEF,
	parameter int MAX_DIMS    = bss_pkg::MAX_DIMS_DEF,
	parameter int COORD_BITS  = bss_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bss_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [bss_pkg::CFG_DATA_BITS-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic action,
	input  logic [7:0] entry_index,
	input  logic signed [23:0] entry_value,
	input  logic signed [23:0] query_x,
	input  logic signed [23:0] query_y,
	input  logic signed [23:0] query_z,
	input  logic force_req,
	input  logic snap,
	output logic out_valid,
	input  logic out_stall,
	output logic [7:0] left_index,
	output logic [7:0] right_index,
	output logic [16:0] alpha,
	output logic has_selection,
	output logic updated
);
	import bss_pkg::*;

	localparam int AW  = $clog2(MAX_ENTRIES);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DFW = COORD_BITS + 2;        // difference width
	localparam int SQW = 2 * DFW + 4;           // distance accumulator width
	localparam int NW  = COORD_BITS + 18;       // alpha numerator width
	localparam int QW  = 18;                    // quotient bits kept
	localparam int PW  = AW + DW + 1;           // flat coordinate index width

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD1, ST_CMP1, ST_DIVSET, ST_DIV, ST_DIVEND,
		ST_RDN, ST_DIFF, ST_WRAP, ST_SQ, ST_NEXT, ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [1:0] num_dims_q;
	logic [CNT_BITS-1:0] num_samples_q, num_coords_q;
	logic angle_wrap_q;

	// coordinate table memory
	logic signed [COORD_BITS-1:0] mem [MAX_ENTRIES];
	logic signed [COORD_BITS-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic rd_en;

	logic signed [COORD_BITS-1:0] active_q [MAX_DIMS];
	logic active_known_q;
	logic [IDX_BITS-1:0] held_left_q, held_right_q;
	logic [ALPHA_BITS-1:0] held_alpha_q;
	logic held_valid_q, updated_q, out_valid_q;

	logic [CW-1:0] ns_cap, nc_cap, count_w;
	logic [CW-1:0] r_q;                 // sample walker
	logic [PW-1:0] ci_q;                // flat coordinate index
	logic [DW-1:0] d_q;
	logic [1:0] dims_q;
	logic snap_q;
	logic signed [COORD_BITS-1:0] prev_q;
	logic signed [DFW-1:0] diff_q;
	logic [SQW-1:0] dist_q, best_dist_q;
	logic found_q;
	logic [CW-1:0] best_q;

	// divider for the 1-D alpha (restoring, one bit per cycle)
	logic [NW-1:0] num_q;
	logic [DFW-1:0] den_q;
	logic [NW:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [5:0] bit_q;

	logic accept_in, q_changed;
	logic signed [COORD_BITS-1:0] q_in [MAX_DIMS];
	logic [NW:0] rem_sh;
	logic signed [COORD_BITS-1:0] act_d;

	function automatic logic [CW-1:0] cap_f(input logic [CNT_BITS-1:0] n);
		if (32'(n) > MAX_ENTRIES)
			return CW'(MAX_ENTRIES);
		return CW'(n);
	endfunction

	assign ns_cap  = cap_f(num_samples_q);
	assign nc_cap  = cap_f(num_coords_q);
	assign count_w = (ns_cap < nc_cap) ? ns_cap : nc_cap;

	assign in_stall  = (state_q != ST_IDLE) || out_valid_q;
	assign accept_in = in_valid && !in_stall;

	always_comb begin
		for (int i = 0; i < MAX_DIMS; i++) begin
			case (i)
				0: q_in[i] = COORD_BITS'(query_x);
				1: q_in[i] = COORD_BITS'(query_y);
				2: q_in[i] = COORD_BITS'(query_z);
				default: q_in[i] = '0;
			endcase
		end
		q_changed = force_req || !active_known_q;
		for (int i = 0; i < MAX_DIMS; i++)
			if (q_in[i] != active_q[i])
				q_changed = 1'b1;
	end

	// memory read address comes from the walker or the flat index
	always_comb begin
		rd_en   = (state_q == ST_RD1) || (state_q == ST_RDN);
		rd_addr = (state_q == ST_RD1) ? r_q[AW-1:0] : ci_q[AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept_in && action == ACT_LOAD)
			mem[AW'(entry_index)] <= COORD_BITS'(entry_value);
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	assign act_d  = active_q[d_q];
	assign rem_sh = {rem_q[NW-1:0], num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			num_dims_q     <= 2'd1;
			num_samples_q  <= '0;
			num_coords_q   <= '0;
			angle_wrap_q   <= 1'b0;
			active_known_q <= 1'b0;
			for (int i = 0; i < MAX_DIMS; i++)
				active_q[i] <= '0;
			held_left_q    <= '0;
			held_right_q   <= '0;
			held_alpha_q   <= '0;
			held_valid_q   <= 1'b0;
			updated_q      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NUM_DIMS:    num_dims_q    <= cfg_data[1:0];
					REG_NUM_SAMPLES: num_samples_q <= cfg_data;
					REG_NUM_COORDS:  num_coords_q  <= cfg_data;
					REG_ANGLE_WRAP:  angle_wrap_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept_in) begin
						updated_q <= (action == ACT_QUERY) && q_changed;
						if (action == ACT_QUERY && q_changed) begin
							// latch the query and start a fresh selection
							active_known_q <= 1'b1;
							for (int i = 0; i < MAX_DIMS; i++)
								active_q[i] <= q_in[i];
							snap_q  <= snap;
							r_q     <= '0;
							ci_q    <= '0;
							d_q     <= '0;
							dist_q  <= '0;
							found_q <= 1'b0;
							dims_q  <= (32'(num_dims_q) > MAX_DIMS) ? 2'(MAX_DIMS) : num_dims_q;
							if (num_dims_q <= 2'd1 || MAX_DIMS < 2) begin
								if (count_w == '0) begin
									held_valid_q <= 1'b0;
									held_left_q  <= '0;
									held_right_q <= '0;
									held_alpha_q <= '0;
									state_q      <= ST_OUT;
								end else begin
									held_valid_q <= 1'b1;
									state_q      <= ST_RD1;
								end
							end else if (ns_cap == '0) begin
								held_valid_q <= 1'b0;
								held_left_q  <= '0;
								held_right_q <= '0;
								if (snap)
									held_alpha_q <= '0;
								state_q <= ST_OUT;
							end else begin
								state_q <= ST_RDN;
							end
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				// one dimension: walk until coord >= query or the last sample
				ST_RD1: state_q <= ST_CMP1;
				ST_CMP1: begin
					if (rd_q < active_q[0]) begin
						if (r_q + 1'b1 >= count_w) begin
							held_left_q  <= IDX_BITS'(count_w - 1'b1);
							held_right_q <= IDX_BITS'(count_w - 1'b1);
							held_alpha_q <= '0;
							state_q      <= ST_OUT;
						end else begin
							prev_q  <= rd_q;
							r_q     <= r_q + 1'b1;
							state_q <= ST_RD1;
						end
					end else if (r_q == '0) begin
						held_left_q  <= '0;
						held_right_q <= '0;
						held_alpha_q <= '0;
						state_q      <= ST_OUT;
					end else begin
						held_left_q  <= IDX_BITS'(r_q - 1'b1);
						held_right_q <= IDX_BITS'(r_q);
						diff_q       <= DFW'(rd_q) - DFW'(prev_q);
						state_q      <= ST_DIVSET;
					end
				end
				ST_DIVSET: begin
					// coord[r] >= q > coord[r-1]: numerator and range are positive
					if (diff_q == '0) begin
						held_alpha_q <= '0;
						state_q      <= ST_OUT;
					end else begin
						num_q   <= NW'(DFW'(active_q[0]) - DFW'(prev_q)) << 16;
						den_q   <= diff_q;
						rem_q   <= '0;
						quo_q   <= '0;
						bit_q   <= 6'(NW - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_sh >= (NW+1)'(den_q)) begin
						rem_q <= rem_sh - (NW+1)'(den_q);
						quo_q <= {quo_q[QW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[QW-2:0], 1'b0};
					end
					num_q <= num_q << 1;
					if (bit_q == '0)
						state_q <= ST_DIVEND;
					else
						bit_q <= bit_q - 1'b1;
				end
				ST_DIVEND: begin
					held_alpha_q <= (quo_q > QW'(ALPHA_ONE)) ? ALPHA_BITS'(ALPHA_ONE)
						: ALPHA_BITS'(quo_q);
					state_q <= ST_OUT;
				end
				// several dimensions: score each sample coordinate by coordinate
				ST_RDN: begin
					if (32'(ci_q) >= 32'(nc_cap))
						state_q <= ST_NEXT;
					else
						state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					diff_q  <= DFW'(rd_q) - DFW'(act_d);
					state_q <= angle_wrap_q ? ST_WRAP : ST_SQ;
				end
				ST_WRAP: begin
					if (diff_q > DFW'(HALF_TURN))
						diff_q <= diff_q - DFW'(FULL_TURN);
					else if (diff_q < -DFW'(HALF_TURN))
						diff_q <= diff_q + DFW'(FULL_TURN);
					else
						state_q <= ST_SQ;
				end
				ST_SQ: begin
					dist_q <= dist_q + SQW'($unsigned(diff_q < 0 ? -diff_q : diff_q)
						* $unsigned(diff_q < 0 ? -diff_q : diff_q));
					ci_q   <= ci_q + 1'b1;
					if (32'(d_q) + 1 >= 32'(dims_q)) begin
						state_q <= ST_NEXT;
					end else begin
						d_q     <= d_q + 1'b1;
						state_q <= ST_RDN;
					end
				end
				ST_NEXT: begin
					if (!found_q || dist_q < best_dist_q) begin
						found_q     <= 1'b1;
						best_dist_q <= dist_q;
						best_q      <= r_q;
					end
					dist_q <= '0;
					d_q    <= '0;
					ci_q   <= PW'((32'(r_q) + 1) * 32'(dims_q));
					r_q    <= r_q + 1'b1;
					if (r_q + 1'b1 >= ns_cap) begin
						held_valid_q <= 1'b1;
						if (!found_q || dist_q < best_dist_q) begin
							held_left_q  <= IDX_BITS'(r_q);
							held_right_q <= IDX_BITS'(r_q);
						end else begin
							held_left_q  <= IDX_BITS'(best_q);
							held_right_q <= IDX_BITS'(best_q);
						end
						if (snap_q)
							held_alpha_q <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_RDN;
					end
				end
				ST_OUT: begin
					// present the item; out_valid holds until the output is taken
					out_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign left_index    = held_left_q;
	assign right_index   = held_right_q;
	assign alpha         = held_alpha_q;
	assign has_selection = held_valid_q;
	assign updated       = updated_q;

`ifndef NO_ASSERTIONS
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall) else $error("item taken while busy");
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (alpha <= 17'd65536)) else $error("alpha above one");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(alpha))) else $error("output dropped");
`endif
endmodule
